FILE: hw/rtl/mrh_pkg.sv
// shared types and constants for the min-rank-with-hysteresis rank calculator
`default_nettype none

package mrh_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } mrh_state_t;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_METRIC_MODE      = 3'd0,
        REG_MIN_HOP_INCREASE = 3'd1,
        REG_MAX_LINK_METRIC  = 3'd2,
        REG_MAX_PATH_COST    = 3'd3,
        REG_SWITCH_THRESHOLD = 3'd4,
        REG_PARENT_SET_LIMIT = 3'd5,
        REG_ETX_UNIT         = 3'd6
    } mrh_reg_idx_t;

    // link metric sources
    localparam logic [1:0] MODE_ETX = 2'd0;
    localparam logic [1:0] MODE_LQI = 2'd1;

    localparam int unsigned RANK_W  = 16;
    localparam int unsigned LQI_W   = 8;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned QUOT_W  = 8;
    localparam int unsigned DIV_CNT_W = $clog2(RANK_W);

    localparam logic [LQI_W-1:0]  LQI_BEST      = 8'hFF;
    localparam logic [1:0]        LQI_SLOPE     = 2'd3;
    localparam logic [RANK_W-1:0] RANK_INFINITE = 16'hFFFF;
    localparam logic [QUOT_W-1:0] QUOT_ALL_ONES = 8'hFF;

    // register reset values
    localparam logic [1:0]         RST_METRIC_MODE      = 2'd0;
    localparam logic [RANK_W-1:0]  RST_MIN_HOP_INCREASE = 16'd256;
    localparam logic [RANK_W-1:0]  RST_MAX_LINK_METRIC  = 16'd512;
    localparam logic [RANK_W-1:0]  RST_MAX_PATH_COST    = 16'd32768;
    localparam logic [RANK_W-1:0]  RST_SWITCH_THRESHOLD = 16'd192;
    localparam logic [LIMIT_W-1:0] RST_PARENT_SET_LIMIT = 8'd3;
    localparam logic [RANK_W-1:0]  RST_ETX_UNIT         = 16'd128;

endpackage

`default_nettype wire

FILE: hw/rtl/min_rank_hysteresis_rank_calc.sv
// Min-rank-with-hysteresis rank calculator: parent entries in, one node rank per parent set out.
//
// The s_ channel carries one parent entry per word, preferred parent first; s_tlast marks the final
// entry of the set. The m_ channel delivers one rank word for each set, on the word that came
// with s_tlast. The user must write registers over the APB-style port while idle; nothing checks it.
//
// Each entry passes from the wait state through evaluation, and through the division state too
// when it enters the rounding maximum, since the rank-by-hop-increase quotient comes out of a
// restoring divider that resolves one quotient bit per cycle. The last entry of a set then
// goes through the hop-increase multiply and the output load. s_tready is high only while the
// sequencer waits for a word.
//
// The result sits in an output register; the next word can be accepted while it waits. If
// the receiver still holds m_tready low when the next result is finished, the sequencer waits
// with that result and takes no new word until the register frees up.
//
// Reset (aresetn low, synchronous) returns all configuration registers to their reset values,
// clears the parent set in progress and drops m_tvalid.
`default_nettype none

module min_rank_hysteresis_rank_calc
    import mrh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [15:0] parent_rank, [31:16] link_etx, [39:32] link_quality
    input  wire logic        s_tuser,   // [0] stats_present
    input  wire logic        s_tlast,   // last_entry

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] rank
    output logic             m_tuser,   // [0] no_preferred_stats

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [1:0]         metric_mode_reg;
    logic [RANK_W-1:0]  min_hop_increase_reg;
    logic [RANK_W-1:0]  max_link_metric_reg;
    logic [RANK_W-1:0]  max_path_cost_reg;
    logic [RANK_W-1:0]  switch_threshold_reg;
    logic [LIMIT_W-1:0] parent_set_limit_reg;
    logic [RANK_W-1:0]  etx_unit_reg;

    // captured entry
    logic [RANK_W-1:0] prank_reg;
    logic [RANK_W-1:0] etx_reg;
    logic [LQI_W-1:0]  lqi_reg;
    logic              stats_reg;
    logic              last_reg;

    // parent set state
    logic               awaiting_first_reg;
    logic [RANK_W-1:0]  preferred_cost_reg;
    logic               preferred_missing_reg;
    logic [QUOT_W-1:0]  max_quotient_reg;
    logic [LIMIT_W-1:0] entries_seen_reg;
    logic               scan_stopped_reg;

    // divider and multiplier
    logic [RANK_W-1:0]    rem_reg;
    logic [RANK_W-1:0]    dvd_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [RANK_W-1:0]    prod_reg;

    // output register
    logic              m_valid_reg;
    logic [RANK_W-1:0] m_rank_reg;
    logic              m_nps_reg;

    mrh_state_t state_reg, state_next;

    logic cfg_write;
    logic [2:0] cfg_idx;

    logic [9:0]        lqi_term;
    logic [RANK_W-1:0] metric;
    logic [RANK_W-1:0] cost;
    logic [RANK_W-1:0] pref_eff;
    logic [RANK_W:0]   cost_limit;
    logic              scan_active;
    logic              entry_ok;
    logic              hop_zero;
    logic              need_div;

    logic [RANK_W:0]   div_shift;
    logic              div_ge;
    logic [RANK_W:0]   div_diff;
    logic [QUOT_W-1:0] div_quot;

    logic [QUOT_W:0]   round_mul;
    logic [RANK_W-1:0] result_rank;
    logic              out_free;
    logic              out_load;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:2];

    always_comb begin
        case (cfg_idx)
            REG_METRIC_MODE:      prdata = {30'd0, metric_mode_reg};
            REG_MIN_HOP_INCREASE: prdata = {16'd0, min_hop_increase_reg};
            REG_MAX_LINK_METRIC:  prdata = {16'd0, max_link_metric_reg};
            REG_MAX_PATH_COST:    prdata = {16'd0, max_path_cost_reg};
            REG_SWITCH_THRESHOLD: prdata = {16'd0, switch_threshold_reg};
            REG_PARENT_SET_LIMIT: prdata = {24'd0, parent_set_limit_reg};
            REG_ETX_UNIT:         prdata = {16'd0, etx_unit_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_mode_reg      <= RST_METRIC_MODE;
            min_hop_increase_reg <= RST_MIN_HOP_INCREASE;
            max_link_metric_reg  <= RST_MAX_LINK_METRIC;
            max_path_cost_reg    <= RST_MAX_PATH_COST;
            switch_threshold_reg <= RST_SWITCH_THRESHOLD;
            parent_set_limit_reg <= RST_PARENT_SET_LIMIT;
            etx_unit_reg         <= RST_ETX_UNIT;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_METRIC_MODE:      metric_mode_reg      <= pwdata[1:0];
                REG_MIN_HOP_INCREASE: min_hop_increase_reg <= pwdata[15:0];
                REG_MAX_LINK_METRIC:  max_link_metric_reg  <= pwdata[15:0];
                REG_MAX_PATH_COST:    max_path_cost_reg    <= pwdata[15:0];
                REG_SWITCH_THRESHOLD: switch_threshold_reg <= pwdata[15:0];
                REG_PARENT_SET_LIMIT: parent_set_limit_reg <= pwdata[7:0];
                REG_ETX_UNIT:         etx_unit_reg         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // entry evaluation
    // ------------------------------------------------------------------
    assign lqi_term = 10'(LQI_SLOPE) * {2'b00, (LQI_BEST - lqi_reg)};

    always_comb begin
        if (!stats_reg) begin
            metric = max_path_cost_reg;
        end else begin
            case (metric_mode_reg)
                MODE_ETX: metric = etx_reg;
                MODE_LQI: metric = {6'd0, lqi_term} + etx_unit_reg;
                default:  metric = max_path_cost_reg;
            endcase
        end
    end

    assign cost        = prank_reg + metric;
    // the first entry of a set sets the preferred cost in the same step
    assign pref_eff    = (awaiting_first_reg && stats_reg) ? cost : preferred_cost_reg;
    assign cost_limit  = {1'b0, pref_eff} + {1'b0, switch_threshold_reg};
    assign scan_active = !scan_stopped_reg && (entries_seen_reg < parent_set_limit_reg);
    assign entry_ok    = stats_reg && (metric < max_link_metric_reg)
                         && (cost < max_path_cost_reg) && ({1'b0, cost} <= cost_limit);
    assign hop_zero    = (min_hop_increase_reg == '0);
    assign need_div    = scan_active && entry_ok && !hop_zero;

    // restoring divider, one quotient bit per cycle; quotient bits shift into dvd_reg
    assign div_shift = {rem_reg, dvd_reg[RANK_W-1]};
    assign div_ge    = (div_shift >= {1'b0, min_hop_increase_reg});
    assign div_diff  = div_shift - {1'b0, min_hop_increase_reg};
    assign div_quot  = {dvd_reg[QUOT_W-2:0], div_ge};

    // result
    assign round_mul   = {1'b0, max_quotient_reg} + 9'd1;
    assign result_rank = preferred_missing_reg ? RANK_INFINITE
                       : ((preferred_cost_reg > prod_reg) ? preferred_cost_reg : prod_reg);
    assign out_free    = !m_valid_reg || m_tready;
    assign out_load    = (state_reg == ST_OUT) && out_free;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (need_div)      state_next = ST_DIV;
                else if (last_reg) state_next = ST_MUL;
                else               state_next = ST_IDLE;
            end
            ST_DIV: begin
                if (div_cnt_reg == '0) state_next = last_reg ? ST_MUL : ST_IDLE;
            end
            ST_MUL: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // captured entry and arithmetic payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            prank_reg <= s_tdata[15:0];
            etx_reg   <= s_tdata[31:16];
            lqi_reg   <= s_tdata[39:32];
            stats_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_EVAL) begin
            rem_reg     <= '0;
            dvd_reg     <= prank_reg;
            div_cnt_reg <= DIV_CNT_W'(RANK_W - 1);
        end else if (state_reg == ST_DIV) begin
            rem_reg     <= div_ge ? div_diff[RANK_W-1:0] : div_shift[RANK_W-1:0];
            dvd_reg     <= {dvd_reg[RANK_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= RANK_W'(min_hop_increase_reg * round_mul);
        end
    end

    // parent set state
    always_ff @(posedge aclk) begin
        if (!aresetn || out_load) begin
            awaiting_first_reg    <= 1'b1;
            preferred_cost_reg    <= '0;
            preferred_missing_reg <= 1'b0;
            max_quotient_reg      <= '0;
            entries_seen_reg      <= '0;
            scan_stopped_reg      <= 1'b0;
        end else if (state_reg == ST_EVAL) begin
            awaiting_first_reg <= 1'b0;
            if (awaiting_first_reg) begin
                if (stats_reg) preferred_cost_reg    <= cost;
                else           preferred_missing_reg <= 1'b1;
            end
            if (scan_active) begin
                if (entry_ok) begin
                    entries_seen_reg <= entries_seen_reg + 1'b1;
                    if (hop_zero) max_quotient_reg <= QUOT_ALL_ONES;
                end else begin
                    scan_stopped_reg <= 1'b1;
                end
            end
        end else if (state_reg == ST_DIV && div_cnt_reg == '0) begin
            if (div_quot > max_quotient_reg) max_quotient_reg <= div_quot;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_rank_reg <= result_rank;
            m_nps_reg  <= preferred_missing_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_rank_reg;
    assign m_tuser  = m_nps_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EVAL))
        else $error("accepted word did not start evaluation");

    a_missing_has_no_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        preferred_missing_reg |-> (preferred_cost_reg == '0))
        else $error("preferred cost set for a parent without statistics");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_valid_reg) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished result not loaded into free output register");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_cnt_reg == '0)
            |=> (state_reg == ST_MUL || state_reg == ST_IDLE))
        else $error("divider overran its bit count");

    a_stopped_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_stopped_reg && state_reg == ST_EVAL) |=> $stable(entries_seen_reg))
        else $error("entry counted after the scan stopped");

endmodule

`default_nettype wire

FILE: sim/min_rank_hysteresis_rank_calc_test.sv
// testbench for the min-rank-with-hysteresis rank calculator: parent sets in, ranks checked
`timescale 1ns / 100ps

module min_rank_hysteresis_rank_calc_test;
    import mrh_pkg::*;

    typedef struct packed {
        logic [15:0] rank;
        logic [15:0] etx;
        logic [7:0]  lqi;
        logic        stats;
        logic        last;
    } parent_entry_t;

    typedef struct packed {
        logic [15:0] rank;
        logic        no_stats;
    } rank_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    min_rank_hysteresis_rank_calc dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // shadow of the register file
    logic [1:0]  cfg_mode      = RST_METRIC_MODE;
    logic [15:0] cfg_hop_inc   = RST_MIN_HOP_INCREASE;
    logic [15:0] cfg_max_link  = RST_MAX_LINK_METRIC;
    logic [15:0] cfg_max_cost  = RST_MAX_PATH_COST;
    logic [15:0] cfg_switch    = RST_SWITCH_THRESHOLD;
    logic [7:0]  cfg_set_limit = RST_PARENT_SET_LIMIT;
    logic [15:0] cfg_etx_unit  = RST_ETX_UNIT;

    // parent set in progress
    logic        first_pending = 1'b1;
    logic [15:0] pref_cost     = '0;
    logic        pref_missing  = 1'b0;
    logic [7:0]  best_quot     = '0;
    logic [7:0]  scanned       = '0;
    logic        scan_done     = 1'b0;

    parent_entry_t pending_entries[$];
    rank_word_t    expected_ranks[$];
    int            err_count = 0;

    int   burst_left = 0;
    int   gap_left   = 0;
    logic word_taken = 1'b0;
    int   stall_mode = 0;
    int   stall_left = 0;

    function automatic void clear_parent_set();
        first_pending = 1'b1;
        pref_cost     = '0;
        pref_missing  = 1'b0;
        best_quot     = '0;
        scanned       = '0;
        scan_done     = 1'b0;
    endfunction

    // folds one parent entry into the set; the last entry yields the node rank
    function automatic void fold_parent(parent_entry_t e);
        logic [15:0] metric;
        logic [15:0] cost;
        logic [16:0] bound;
        logic [7:0]  quot;
        logic [15:0] mono;
        logic        ok;
        rank_word_t  w;
        if (!e.stats)
            metric = cfg_max_cost;
        else if (cfg_mode == MODE_ETX)
            metric = e.etx;
        else if (cfg_mode == MODE_LQI)
            metric = 16'(32'd3 * (32'(LQI_BEST) - 32'(e.lqi)) + 32'(cfg_etx_unit));
        else
            metric = cfg_max_cost;
        cost = e.rank + metric;
        if (first_pending) begin
            first_pending = 1'b0;
            if (e.stats)
                pref_cost = cost;
            else
                pref_missing = 1'b1;
        end
        if (!scan_done && scanned < cfg_set_limit) begin
            bound = {1'b0, pref_cost} + {1'b0, cfg_switch};
            ok = e.stats && metric < cfg_max_link && cost < cfg_max_cost
                 && {1'b0, cost} <= bound;
            if (ok) begin
                quot = (cfg_hop_inc == 0) ? QUOT_ALL_ONES : 8'(e.rank / cfg_hop_inc);
                if (quot > best_quot)
                    best_quot = quot;
                scanned = scanned + 1'b1;
            end else begin
                scan_done = 1'b1;
            end
        end
        if (e.last) begin
            if (pref_missing) begin
                w.rank     = RANK_INFINITE;
                w.no_stats = 1'b1;
            end else begin
                mono       = 16'(32'(cfg_hop_inc) * (32'(best_quot) + 32'd1));
                w.rank     = (pref_cost > mono) ? pref_cost : mono;
                w.no_stats = 1'b0;
            end
            expected_ranks.push_back(w);
            clear_parent_set();
        end
    endfunction

    // sender: bursts of words with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_entries.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_entries[0].lqi, pending_entries[0].etx,
                             pending_entries[0].rank};
                s_tuser  <= pending_entries[0].stats;
                s_tlast  <= pending_entries[0].last;
                void'(pending_entries.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        stall_left <= $urandom_range(5, 30);
                end
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        parent_entry_t e;
        rank_word_t    exp_word;
        word_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            e.rank  = s_tdata[15:0];
            e.etx   = s_tdata[31:16];
            e.lqi   = s_tdata[39:32];
            e.stats = s_tuser;
            e.last  = s_tlast;
            fold_parent(e);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ranks.size() == 0) begin
                $error("rank word %0d with none expected", m_tdata);
                err_count++;
            end else begin
                exp_word = expected_ranks.pop_front();
                if (m_tdata !== exp_word.rank) begin
                    $error("rank: expected %0d, actual %0d", exp_word.rank, m_tdata);
                    err_count++;
                end
                if (m_tuser !== exp_word.no_stats) begin
                    $error("no_preferred_stats: expected %0d, actual %0d",
                           exp_word.no_stats, m_tuser);
                    err_count++;
                end
            end
        end
    end

    task automatic write_reg(mrh_reg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_METRIC_MODE:      cfg_mode      = val[1:0];
            REG_MIN_HOP_INCREASE: cfg_hop_inc   = val;
            REG_MAX_LINK_METRIC:  cfg_max_link  = val;
            REG_MAX_PATH_COST:    cfg_max_cost  = val;
            REG_SWITCH_THRESHOLD: cfg_switch    = val;
            REG_PARENT_SET_LIMIT: cfg_set_limit = val[7:0];
            REG_ETX_UNIT:         cfg_etx_unit  = val;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(logic [1:0] mode, logic [15:0] hop, logic [15:0] max_link,
                                  logic [15:0] max_cost, logic [15:0] sw, logic [7:0] lim,
                                  logic [15:0] unit);
        write_reg(REG_METRIC_MODE, {14'd0, mode});
        write_reg(REG_MIN_HOP_INCREASE, hop);
        write_reg(REG_MAX_LINK_METRIC, max_link);
        write_reg(REG_MAX_PATH_COST, max_cost);
        write_reg(REG_SWITCH_THRESHOLD, sw);
        write_reg(REG_PARENT_SET_LIMIT, {8'd0, lim});
        write_reg(REG_ETX_UNIT, unit);
    endtask

    function automatic logic [15:0] pick_word(logic [15:0] typical);
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return typical;
            4:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 2 * int'(typical) + 1));
        endcase
    endfunction

    function automatic void add_entry(logic [15:0] rank, logic [15:0] etx, logic [7:0] lqi,
                                      logic stats, logic last);
        parent_entry_t e;
        e.rank  = rank;
        e.etx   = etx;
        e.lqi   = lqi;
        e.stats = stats;
        e.last  = last;
        pending_entries.push_back(e);
    endfunction

    // one parent set; mostly plausible parents near the preferred rank, some noise
    function automatic int add_parent_set();
        int          len;
        logic [15:0] base;
        logic [15:0] rank;
        logic [15:0] etx;
        logic        noise;
        noise = ($urandom_range(0, 6) == 0);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
        base  = 16'($urandom_range(0, 40000));
        for (int i = 0; i < len; i++) begin
            if (noise) begin
                rank = 16'($urandom_range(0, 65535));
                etx  = 16'($urandom_range(0, 65535));
            end else begin
                case ($urandom_range(0, 9))
                    6:       rank = 16'h0000;
                    7:       rank = 16'hFFFF;
                    8, 9:    rank = 16'($urandom_range(0, 65535));
                    default: rank = base + 16'($urandom_range(0, 400));
                endcase
                case ($urandom_range(0, 9))
                    7:       etx = 16'h0000;
                    8:       etx = 16'hFFFF;
                    9:       etx = 16'($urandom_range(0, 65535));
                    default: etx = 16'($urandom_range(0, 700));
                endcase
            end
            add_entry(rank, etx, 8'($urandom_range(0, 255)),
                      noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0),
                      i == len - 1);
        end
        return len;
    endfunction

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_entries.size() != 0 || s_tvalid || expected_ranks.size() != 0)
            @(negedge aclk);
        // words without a result may still be in the sequencer
        repeat (30) @(negedge aclk);
    endtask

    initial begin : stimulus
        int random_items;
        int phase_items;
        int phase;
        logic [7:0] lim;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: single entries, threshold edge, scan stop, set limit
        add_entry(16'd0, 16'd0, 8'd0, 1'b1, 1'b1);
        add_entry(16'd0, 16'd0, 8'd0, 1'b0, 1'b1);
        add_entry(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        add_entry(16'd1000, 16'd100, 8'd10, 1'b1, 1'b0);
        add_entry(16'd1200, 16'd50, 8'd20, 1'b1, 1'b0);
        add_entry(16'd1000, 16'd600, 8'd30, 1'b1, 1'b0);
        add_entry(16'd5000, 16'd10, 8'd40, 1'b1, 1'b1);
        for (int i = 0; i < 5; i++)
            add_entry(16'(900 + 40 * i), 16'd20, 8'(i), 1'b1, i == 4);
        add_entry(16'd700, 16'd10, 8'd200, 1'b0, 1'b0);
        add_entry(16'd800, 16'd10, 8'd200, 1'b1, 1'b0);
        add_entry(16'd900, 16'd10, 8'd200, 1'b1, 1'b1);
        add_entry(16'd2000, 16'd100, 8'd100, 1'b1, 1'b0);
        add_entry(16'd2100, 16'd10, 8'd100, 1'b0, 1'b0);
        add_entry(16'd2050, 16'd10, 8'd100, 1'b1, 1'b1);
        add_entry(16'd1000, 16'd100, 8'd0, 1'b1, 1'b0);
        add_entry(16'd1192, 16'd100, 8'd0, 1'b1, 1'b0);
        add_entry(16'd1193, 16'd100, 8'd0, 1'b1, 1'b1);
        wait_idle();

        // all registers at their lowest
        stall_mode = 1;
        write_all_regs(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
        phase_items = 0;
        while (phase_items < 20)
            phase_items += add_parent_set();
        wait_idle();

        // all registers at their highest, then LQI mapping with wrapping scale
        stall_mode = 2;
        write_all_regs(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        phase_items = 0;
        while (phase_items < 20)
            phase_items += add_parent_set();
        wait_idle();
        write_all_regs(MODE_LQI, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_entry(16'd0, 16'd0, 8'd0, 1'b1, 1'b0);
        add_entry(16'hFF00, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        add_entry(16'd300, 16'd0, 8'hFF, 1'b1, 1'b1);
        wait_idle();

        random_items = 0;
        phase = 0;
        while (random_items < 600) begin
            stall_mode = phase % 3;
            case ($urandom_range(0, 4))
                0:       lim = 8'd0;
                1:       lim = 8'hFF;
                2:       lim = 8'd1;
                default: lim = 8'($urandom_range(2, 8));
            endcase
            write_all_regs(2'(phase % 4), pick_word(16'd256), pick_word(16'd512),
                           pick_word(16'd32768), pick_word(16'd192), lim, pick_word(16'd128));
            phase_items = 0;
            while (phase_items < 50)
                phase_items += add_parent_set();
            random_items += phase_items;
            wait_idle();
            phase++;
        end

        if (err_count == 0 && expected_ranks.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (expected_ranks.size() != 0)
                $error("%0d rank words never arrived", expected_ranks.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
